FILE: design/osc_pkg.sv
// Shared types and constants for the octagon strong closure block.
`default_nettype none
package osc_pkg;
  localparam logic [1:0] FUNC_LOAD  = 2'd0;
  localparam logic [1:0] FUNC_CLOSE = 2'd1;
  localparam logic [1:0] FUNC_READ  = 2'd2;
  localparam logic [1:0] FUNC_NOP   = 2'd3;
  localparam int unsigned VARS_W = 4;
  localparam int unsigned NODE_W = 4;
  localparam logic KIND_READ  = 1'b0;
  localparam logic KIND_CLOSE = 1'b1;

  // One relaxation request from the sequencer to the bound unit
  typedef struct packed {
    logic       start;
    logic [1:0] mode;
  } osc_ctl_t;

  localparam logic [1:0] MODE_SUM  = 2'd0;
  localparam logic [1:0] MODE_HALF = 2'd1;
endpackage
`default_nettype wire

FILE: design/osc_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`default_nettype none
module osc_ram #(
  parameter int unsigned WIDTH = 33,
  parameter int unsigned DEPTH = 144,
  parameter int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

FILE: design/osc_bound_unit.sv
// Saturating bound adder with optional floor halving of both operands.
`default_nettype none
module osc_bound_unit #(
  parameter int unsigned BW = 32
) (
  input  wire logic          half_en,
  input  wire logic [BW-1:0] a_v,
  input  wire logic          a_inf,
  input  wire logic [BW-1:0] b_v,
  input  wire logic          b_inf,
  output logic      [BW-1:0] s_v,
  output logic               s_inf
);
  logic signed [BW-1:0] ah, bh;
  logic signed [BW:0]   sum;
  logic signed [BW:0]   bmax, bmin;

  // Halve (arithmetic shift floors) then add with saturation
  always_comb begin
    ah = half_en ? ($signed(a_v) >>> 1) : $signed(a_v);
    bh = half_en ? ($signed(b_v) >>> 1) : $signed(b_v);
    sum = {ah[BW-1], ah} + {bh[BW-1], bh};
    bmax = {2'b00, {(BW-1){1'b1}}};
    bmin = {2'b11, {(BW-1){1'b0}}};
    s_inf = 1'b0;
    s_v = sum[BW-1:0];
    if (a_inf || b_inf || sum > bmax) begin
      s_inf = 1'b1;
      s_v = '0;
    end else if (sum < bmin) begin
      s_v = bmin[BW-1:0];
    end
  end
endmodule
`default_nettype wire

FILE: design/octagon_strong_closure_core.sv
// Top level of the octagon strong closure block: sequencer, matrix RAM, bound unit.
// Usage:
//  Input channel in_* carries a transaction of func, row, col, bound_value and
//  bound_infinite; it is accepted when in_valid is high and in_stall is low.
//  func 0 loads an entry (no result), func 2 reads one, func 1 runs the
//  closure, func 3 does nothing.
//  Result channel out_* carries read_value, read_infinite, is_empty and kind;
//  the receiver holds it with out_stall, and the block then takes no new input
//  until the result leaves.
//  cfg_we with cfg_wdata sets vars_in_use (reset 8); write it while idle.
//  A load writes the RAM when it is accepted; a read registers the RAM output
//  and then the result. A closure of n = 2*vars nodes (at most 2*MAX_VARS)
//  runs a pivot pass, then strengthening, then a diagonal check. Its pace is
//  set by the one RAM read port: every relaxation reads the pivot operand and
//  the target entry in turn.
//  One transaction is handled at a time; a load frees the input on the next cycle.
//  Reset (rst_n low, synchronous) clears control state and the empty flag;
//  matrix contents stay undefined until loaded.
`default_nettype none
module octagon_strong_closure_core #(
  parameter int unsigned MAX_VARS = 8,
  parameter int unsigned BOUND_WIDTH = 32
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_we,
  input  wire logic [3:0]  cfg_wdata,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  in_func,
  input  wire logic [3:0]  in_row,
  input  wire logic [3:0]  in_col,
  input  wire logic [31:0] in_bound_value,
  input  wire logic        in_bound_infinite,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      out_read_value,
  output logic             out_read_infinite,
  output logic             out_is_empty,
  output logic             out_kind
);
  localparam int unsigned BW = BOUND_WIDTH;
  localparam int unsigned DEPTH = 2 * MAX_VARS * (MAX_VARS + 1);
  localparam int unsigned AW = $clog2(DEPTH + 1);
  localparam int unsigned NW = $clog2(2 * MAX_VARS + 2);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_RD   = 4'd1;
  localparam logic [3:0] S_KI   = 4'd3;  // fetch ik
  localparam logic [3:0] S_KI2  = 4'd4;  // fetch ik2
  localparam logic [3:0] S_OPA  = 4'd5;  // fetch operand
  localparam logic [3:0] S_OPT  = 4'd6;  // fetch target
  localparam logic [3:0] S_UPD  = 4'd7;  // relax and write
  localparam logic [3:0] S_SHI  = 4'd8;  // fetch m[i][i^1]
  localparam logic [3:0] S_DGA  = 4'd9;  // fetch diagonal
  localparam logic [3:0] S_DGW  = 4'd10; // test and clear
  localparam logic [3:0] S_DONE = 4'd11;
  localparam logic [3:0] S_WAIT = 4'd12;
  localparam logic [3:0] S_SHW  = 4'd13; // latch m[i][i^1]

  logic [3:0] st_r, st_nxt;
  logic [3:0] vars_r;
  logic       empty_r, empty_nxt;
  logic       phase_r, phase_nxt;   // 0 pivot pass, 1 strengthening
  logic [NW-1:0] k_r, k_nxt, i_r, i_nxt, j_r, j_nxt;
  logic       sub_r, sub_nxt;       // second relaxation of the pair
  logic [BW:0] ik_r, ik_nxt, ik2_r, ik2_nxt, opa_r, opa_nxt;
  logic       oob_r, oob_nxt;
  logic       ov_r, ov_nxt, okind_r, okind_nxt, oinf_r, oinf_nxt;
  logic [31:0] oval_r, oval_nxt;

  logic [NW-1:0] n_nodes;
  logic [AW-1:0] raddr, waddr;
  logic          we;
  logic [BW:0]   wdata, rdata;

  // Half-matrix position of (i, j), with coherent mapping above the diagonal
  function automatic logic [AW-1:0] hp(input logic [NW-1:0] i, input logic [NW-1:0] j);
    logic [2*NW+1:0] t;
    t = ({{(NW+2){1'b0}}, i} + 1) * ({{(NW+2){1'b0}}, i} + 1);
    hp = AW'(j) + AW'(t >> 1);
  endfunction
  function automatic logic [AW-1:0] hp2(input logic [NW-1:0] i, input logic [NW-1:0] j);
    if (j > (i | NW'(1))) hp2 = hp(j ^ NW'(1), i ^ NW'(1));
    else hp2 = hp(i, j);
  endfunction

  always_comb begin
    if (vars_r > MAX_VARS) n_nodes = NW'(2 * MAX_VARS);
    else n_nodes = NW'({vars_r, 1'b0});
  end

  osc_ram #(.WIDTH(BW + 1), .DEPTH(DEPTH + 1), .AW(AW)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  // Pair geometry for the pivot loop
  logic [NW-1:0] i2, br, k2;
  logic          lower;
  assign i2 = i_r | NW'(1);
  assign k2 = k_r ^ NW'(1);
  assign br = (k_r < i2) ? k_r : i2;
  assign lower = (j_r <= br);

  // Shared bound unit
  logic [BW-1:0] sa_v, sb_v, s_v;
  logic          sa_inf, sb_inf, s_inf, half_en;
  osc_bound_unit #(.BW(BW)) u_unit (
    .half_en(half_en), .a_v(sa_v), .a_inf(sa_inf), .b_v(sb_v), .b_inf(sb_inf),
    .s_v(s_v), .s_inf(s_inf)
  );
  always_comb begin
    half_en = phase_r;
    if (phase_r) begin
      sa_v = opa_r[BW-1:0]; sa_inf = opa_r[BW];
      sb_v = ik_r[BW-1:0];  sb_inf = ik_r[BW];
    end else if (!sub_r) begin
      sa_v = ik_r[BW-1:0];  sa_inf = ik_r[BW];
      sb_v = opa_r[BW-1:0]; sb_inf = opa_r[BW];
    end else begin
      sa_v = ik2_r[BW-1:0]; sa_inf = ik2_r[BW];
      sb_v = opa_r[BW-1:0]; sb_inf = opa_r[BW];
    end
  end

  // Clamp loaded value into the bound range
  logic signed [31:0] inv;
  logic [BW-1:0] ld_v;
  always_comb begin
    inv = $signed(in_bound_value);
    if (BW >= 32) ld_v = BW'(inv);
    else if (inv > $signed(33'((64'd1 << (BW - 1)) - 1))) ld_v = {1'b0, {(BW-1){1'b1}}};
    else if (inv < -$signed(33'(64'd1 << (BW - 1)))) ld_v = {1'b1, {(BW-1){1'b0}}};
    else ld_v = BW'(inv);
  end

  // Clamp stored value into 32 bits for read-back
  function automatic logic [31:0] clamp32(input logic [BW-1:0] v);
    logic signed [63:0] x;
    x = 64'($signed(v));
    if (x > 64'sh7FFFFFFF) clamp32 = 32'h7FFFFFFF;
    else if (x < -64'sh80000000) clamp32 = 32'h80000000;
    else clamp32 = x[31:0];
  endfunction

  logic accept;
  assign accept = in_valid && !in_stall;
  assign in_stall = (st_r != S_IDLE) || ov_r;

  // Sequencer
  always_comb begin
    st_nxt = st_r; empty_nxt = empty_r; phase_nxt = phase_r;
    k_nxt = k_r; i_nxt = i_r; j_nxt = j_r; sub_nxt = sub_r;
    ik_nxt = ik_r; ik2_nxt = ik2_r; opa_nxt = opa_r; oob_nxt = oob_r;
    ov_nxt = ov_r; okind_nxt = okind_r; oinf_nxt = oinf_r; oval_nxt = oval_r;
    raddr = '0; waddr = '0; we = 1'b0; wdata = '0;
    if (ov_r && !out_stall) ov_nxt = 1'b0;
    case (st_r)
      S_IDLE: begin
        if (accept) begin
          case (in_func)
            osc_pkg::FUNC_LOAD: begin
              if (NW'(in_row) < n_nodes && NW'(in_col) < n_nodes && in_row < 2*MAX_VARS &&
                  in_col < 2*MAX_VARS) begin
                we = 1'b1;
                waddr = hp2(NW'(in_row), NW'(in_col));
                wdata = in_bound_infinite ? {1'b1, {BW{1'b0}}} : {1'b0, ld_v};
              end
            end
            osc_pkg::FUNC_READ: begin
              oob_nxt = !(in_row < 2*MAX_VARS && in_col < 2*MAX_VARS &&
                          NW'(in_row) < n_nodes && NW'(in_col) < n_nodes);
              raddr = hp2(NW'(in_row), NW'(in_col));
              st_nxt = S_RD;
            end
            osc_pkg::FUNC_CLOSE: begin
              k_nxt = '0; i_nxt = '0; j_nxt = '0; sub_nxt = 1'b0; phase_nxt = 1'b0;
              st_nxt = (n_nodes == '0) ? S_DONE : S_KI;
              empty_nxt = 1'b0;
            end
            default: ;
          endcase
        end
      end
      // Read data is on the RAM output now
      S_RD: begin
        oinf_nxt = oob_r ? 1'b1 : rdata[BW];
        oval_nxt = oob_r ? 32'd0 : clamp32(rdata[BW-1:0]);
        okind_nxt = osc_pkg::KIND_READ;
        ov_nxt = 1'b1;
        st_nxt = S_WAIT;
      end
      S_KI: begin
        raddr = hp2(i_r, k_r);
        st_nxt = S_KI2;
      end
      S_KI2: begin
        ik_nxt = rdata;
        raddr = hp2(i_r, k2);
        st_nxt = S_OPA;
      end
      S_OPA: begin
        if (!phase_r && j_r == '0 && !sub_r) ik2_nxt = rdata;
        if (phase_r) raddr = hp(j_r ^ NW'(1), j_r);
        else if (lower) raddr = hp(sub_r ? k2 : k_r, j_r);
        else raddr = hp(j_r ^ NW'(1), sub_r ? k_r : k2);
        st_nxt = S_OPT;
      end
      S_OPT: begin
        opa_nxt = rdata;
        raddr = hp(i_r, j_r);
        st_nxt = S_UPD;
      end
      S_UPD: begin
        if (!s_inf && (rdata[BW] || $signed(s_v) < $signed(rdata[BW-1:0]))) begin
          we = 1'b1; waddr = hp(i_r, j_r); wdata = {1'b0, s_v};
        end
        st_nxt = S_OPA;
        if (!phase_r && !sub_r) begin
          sub_nxt = 1'b1;
        end else begin
          sub_nxt = 1'b0;
          if (j_r != i2) j_nxt = j_r + NW'(1);
          else begin
            j_nxt = '0;
            if (i_r != n_nodes - NW'(1)) begin
              i_nxt = i_r + NW'(1);
              st_nxt = phase_r ? S_SHI : S_KI;
            end else begin
              i_nxt = '0;
              if (!phase_r && k_r != n_nodes - NW'(1)) begin
                k_nxt = k_r + NW'(1); st_nxt = S_KI;
              end else if (!phase_r) begin
                phase_nxt = 1'b1; st_nxt = S_SHI;
              end else st_nxt = S_DGA;
            end
          end
        end
      end
      S_SHI: begin
        raddr = hp(i_r, i_r ^ NW'(1));
        st_nxt = S_SHW;
      end
      S_SHW: begin
        ik_nxt = rdata;
        st_nxt = S_OPA;
      end
      S_DGA: begin
        raddr = hp(i_r, i_r);
        st_nxt = S_DGW;
      end
      S_DGW: begin
        if (!rdata[BW] && rdata[BW-1]) begin
          empty_nxt = 1'b1; st_nxt = S_DONE;
        end else begin
          we = 1'b1; waddr = hp(i_r, i_r); wdata = '0;
          if (i_r == n_nodes - NW'(1)) st_nxt = S_DONE;
          else begin
            i_nxt = i_r + NW'(1); st_nxt = S_DGA;
          end
        end
      end
      S_DONE: begin
        oinf_nxt = 1'b0; oval_nxt = '0; okind_nxt = osc_pkg::KIND_CLOSE;
        ov_nxt = 1'b1; st_nxt = S_WAIT;
      end
      S_WAIT: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; vars_r <= 4'd8; empty_r <= 1'b0; ov_r <= 1'b0;
    end else begin
      st_r <= st_nxt; empty_r <= empty_nxt; ov_r <= ov_nxt;
      if (cfg_we) vars_r <= cfg_wdata;
    end
    phase_r <= phase_nxt; k_r <= k_nxt; i_r <= i_nxt; j_r <= j_nxt; sub_r <= sub_nxt;
    ik_r <= ik_nxt; ik2_r <= ik2_nxt; opa_r <= opa_nxt; oob_r <= oob_nxt;
    okind_r <= okind_nxt; oinf_r <= oinf_nxt; oval_r <= oval_nxt;
  end

  assign out_valid = ov_r;
  assign out_read_value = oval_r;
  assign out_read_infinite = oinf_r;
  assign out_is_empty = empty_r;
  assign out_kind = okind_r;

`ifndef SYNTHESIS
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r != S_IDLE) |-> !accept) else $error("input taken while busy");
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_kind))) else $error("result dropped");
  a_close_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_kind == osc_pkg::KIND_CLOSE) |-> !out_read_infinite)
    else $error("closure result carries infinity");
`endif
endmodule
`default_nettype wire
